// ===== sv/s5ste_pkg.sv =====
package s5ste_pkg;

    // Defaults
    localparam int POSITION_BITS_DEF = 32;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int WORD_W   = 16;
    localparam int WIN_W    = 48;
    localparam int OUT_W    = 40;

    // Parse phases
    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_PKGOP  = 3'd1;
    localparam logic [2:0] PH_LEAD   = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_TYPA   = 3'd4;
    localparam logic [2:0] PH_TYPB   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PKG    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_NAME   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd4;

    // AML constants
    localparam logic [31:0] NAME_S5        = 32'h5F53355F;
    localparam logic [7:0]  OP_PACKAGE     = 8'h12;
    localparam logic [7:0]  OP_NAME        = 8'h08;
    localparam logic [7:0]  OP_BYTE_PREFIX = 8'h0A;
    localparam logic [7:0]  BACKSLASH      = 8'h5C;
    localparam int          SLP_SHIFT      = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word_a;
        logic [WORD_W-1:0]   word_b;
    } result_t;

    function automatic logic [WORD_W-1:0] shift_word(input logic [BYTE_W-1:0] v);
        logic [WORD_W-1:0] w;
        begin
            w = {{(WORD_W-BYTE_W){1'b0}}, v};
            return w << SLP_SHIFT;
        end
    endfunction

endpackage

// ===== sv/aml_s5_sleep_type_extractor_unit.sv =====
// Channel  | Role        | Payload
// ---------+-------------+------------------------------------------------
// s_axis   | body bytes  | tdata[7:0] data_byte, tlast last_byte
// m_axis   | one result  | tdata[2:0] status, [18:3] sleep_word_a,
//          | per body    |   [34:19] sleep_word_b, [39:35] zero
//
// Each byte request enters an input register and is parsed by one pass of compare and
// phase logic; one byte per cycle is sustained while no last byte waits. The output
// register takes the result when the last byte request leaves the input register, so a
// result then sits in the output register. Reset (rst_n low, asynchronous) clears the
// parse state and both valid flags. Only a last byte waits on a full output register;
// other bytes keep flowing while a result is held.
module aml_s5_sleep_type_extractor_unit
    import s5ste_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tlast,   // last_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [2:0] status, [18:3] sleep_word_a,
                                        // [34:19] sleep_word_b, rest zero
);

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Parse state
    logic [WIN_W-1:0]         win_reg,   win_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic [2:0]               phase_reg, phase_next;
    logic [1:0]               skip_reg,  skip_next;
    logic [WORD_W-1:0]        word_a_reg, word_a_next;
    logic [STATUS_W-1:0]      outcome_reg, outcome_next;

    // Output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, result;

    logic              advance;
    logic [BYTE_W-1:0] b;
    logic [WIN_W-1:0]  win_shift;
    logic              name_ok;

    // Hold a last byte only while a result still waits downstream.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign b         = in_byte_reg;
    assign win_shift = {win_reg[WIN_W-BYTE_W-1:0], b};
    assign name_ok   = (win_shift[39:32] == OP_NAME) ||
                       (pos_reg >= POSITION_BITS'(5) && win_shift[47:40] == OP_NAME &&
                        win_shift[39:32] == BACKSLASH);

    always_comb
    begin
        win_next     = (phase_reg == PH_DONE) ? win_reg : win_shift;
        pos_next     = (pos_reg != '1) ? pos_reg + POSITION_BITS'(1) : pos_reg;
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        word_a_next  = word_a_reg;
        outcome_next = outcome_reg;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (pos_reg >= POSITION_BITS'(3) && win_shift[31:0] == NAME_S5)
                begin
                    if (pos_reg == POSITION_BITS'(3))
                    begin
                        // match at body offset 0 is rejected
                        outcome_next = ST_NOT_FOUND;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        outcome_next = name_ok ? ST_OK : ST_NO_NAME;
                        phase_next   = PH_PKGOP;
                    end
                end
            end
            PH_PKGOP:
            begin
                if (b != OP_PACKAGE)
                begin
                    outcome_next = ST_NO_PKG;
                    phase_next   = PH_DONE;
                end
                else if (outcome_reg != ST_OK)
                    phase_next = PH_DONE;
                else
                    phase_next = PH_LEAD;
            end
            PH_LEAD:
            begin
                skip_next  = b[7:6];
                phase_next = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (skip_reg == 2'd0)
                    phase_next = PH_TYPA;
                else
                    skip_next = skip_reg - 2'd1;
            end
            PH_TYPA:
            begin
                if (skip_reg == 2'd0 && b == OP_BYTE_PREFIX)
                    skip_next = 2'd1;
                else
                begin
                    word_a_next = shift_word(b);
                    skip_next   = 2'd0;
                    phase_next  = PH_TYPB;
                end
            end
            PH_TYPB:
            begin
                if (skip_reg == 2'd0 && b == OP_BYTE_PREFIX)
                    skip_next = 2'd1;
                else
                begin
                    skip_next    = 2'd0;
                    outcome_next = ST_OK;
                    phase_next   = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        // Result for a body ending on this byte
        result.status = ST_TRUNC;
        result.word_a = '0;
        result.word_b = '0;
        if (phase_next == PH_SEARCH)
            result.status = ST_NOT_FOUND;
        else if (phase_next == PH_DONE)
        begin
            result.status = outcome_next;
            if (outcome_next == ST_OK)
            begin
                result.word_a = word_a_next;
                result.word_b = shift_word(win_next[BYTE_W-1:0]);
            end
        end

        // Drop the parse state once a body is closed
        if (in_last_reg)
        begin
            win_next     = '0;
            pos_next     = '0;
            phase_next   = PH_SEARCH;
            skip_next    = 2'd0;
            word_a_next  = '0;
            outcome_next = ST_NOT_FOUND;
        end

        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
            pos_reg       <= '0;
            phase_reg     <= PH_SEARCH;
            skip_reg      <= 2'd0;
            word_a_reg    <= '0;
            outcome_reg   <= ST_NOT_FOUND;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                win_reg     <= win_next;
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                skip_reg    <= skip_next;
                word_a_reg  <= word_a_next;
                outcome_reg <= outcome_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-STATUS_W-2*WORD_W){1'b0}},
                       out_reg.word_b, out_reg.word_a, out_reg.status};

    // A closed body always lands in the output register.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_valid_reg)
        else $error("last byte did not produce a result");

    // Parse state restarts after each body.
    a_state_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> phase_reg == PH_SEARCH && pos_reg == '0)
        else $error("parse state not cleared after body end");

    // Sleep words are zero unless the status is ok.
    a_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |->
            out_reg.word_a == '0 && out_reg.word_b == '0)
        else $error("nonzero sleep word on failed parse");

    // No last byte is consumed while a result is still blocked.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

endmodule

// ===== tb/aml_s5_sleep_type_extractor_unit_tb.sv =====
`timescale 1ns / 1ps

module aml_s5_sleep_type_extractor_unit_tb;
    import s5ste_pkg::*;

    localparam int POS_W       = POSITION_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1650;
    localparam int PHASE_SPAN  = 200;

    typedef logic [7:0] body_t[$];

    // One body byte waiting to be offered on the input stream, with the
    // traffic shape in force when it was queued.
    typedef struct {
        logic [7:0] data;
        logic       is_last;
        int         idle_pct;
        int         stall_pct;
        bit         drain_first;
    } byte_req_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    byte_req_t           byte_reqs[$];
    result_t             s5_results_due[$];
    int                  recv_stall     = 0;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    int                  gen_idle       = 0;
    int                  gen_stall      = 0;
    bit                  gen_drain      = 1'b0;
    int                  bytes_queued   = 0;

    // Scan state mirrored from the block: six-byte window, body offset,
    // parse phase, skip counter or prefix flag, first sleep type word, verdict.
    logic [WIN_W-1:0]    scan_window = '0;
    logic [POS_W-1:0]    body_count  = '0;
    logic [2:0]          scan_phase  = PH_SEARCH;
    logic [1:0]          skip_left   = '0;
    logic [WORD_W-1:0]   slp_a_word  = '0;
    logic [STATUS_W-1:0] verdict     = ST_NOT_FOUND;

    aml_s5_sleep_type_extractor_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Restart the scan for the next body.
    task automatic clear_scan();
        scan_window = '0;
        body_count  = '0;
        scan_phase  = PH_SEARCH;
        skip_left   = '0;
        slp_a_word  = '0;
        verdict     = ST_NOT_FOUND;
    endtask

    // Advance the scan by one accepted byte; on the last byte of a body,
    // queue the status and sleep words the block must return.
    task automatic parse_body_byte(input logic [7:0] b, input logic is_last);
        logic [POS_W-1:0]  at;
        logic [WORD_W-1:0] wide;
        result_t           r;
        at = body_count;
        if (scan_phase != PH_DONE)
            scan_window = {scan_window[WIN_W-9:0], b};
        case (scan_phase)
            PH_SEARCH:
            begin
                if (at >= 3 && scan_window[31:0] == NAME_S5) begin
                    if (at == 3) begin
                        // match at offset 0 counts as not found
                        verdict    = ST_NOT_FOUND;
                        scan_phase = PH_DONE;
                    end
                    else begin
                        // name op right before, or name op plus root prefix
                        if (scan_window[39:32] == OP_NAME ||
                            (at >= 5 && scan_window[47:40] == OP_NAME &&
                             scan_window[39:32] == BACKSLASH))
                            verdict = ST_OK;
                        else
                            verdict = ST_NO_NAME;
                        scan_phase = PH_PKGOP;
                    end
                end
            end
            PH_PKGOP:
            begin
                // a missing package op outranks a missing name op
                if (b != OP_PACKAGE) begin
                    verdict    = ST_NO_PKG;
                    scan_phase = PH_DONE;
                end
                else if (verdict != ST_OK)
                    scan_phase = PH_DONE;
                else
                    scan_phase = PH_LEAD;
            end
            PH_LEAD:
            begin
                skip_left  = b[7:6];
                scan_phase = PH_SKIP;
            end
            PH_SKIP:
            begin
                // extra length bytes, then the element count
                if (skip_left == 0)
                    scan_phase = PH_TYPA;
                else
                    skip_left = skip_left - 2'd1;
            end
            PH_TYPA:
            begin
                if (skip_left == 0 && b == OP_BYTE_PREFIX)
                    skip_left = 2'd1;
                else begin
                    wide       = {8'h00, b};
                    slp_a_word = wide << SLP_SHIFT;
                    skip_left  = '0;
                    scan_phase = PH_TYPB;
                end
            end
            PH_TYPB:
            begin
                if (skip_left == 0 && b == OP_BYTE_PREFIX)
                    skip_left = 2'd1;
                else begin
                    skip_left  = '0;
                    verdict    = ST_OK;
                    scan_phase = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
        if (at != '1)
            body_count = at + 1'b1;
        if (is_last) begin
            r.word_a = '0;
            r.word_b = '0;
            if (scan_phase == PH_SEARCH)
                r.status = ST_NOT_FOUND;
            else if (scan_phase == PH_DONE) begin
                r.status = verdict;
                if (verdict == ST_OK) begin
                    wide     = {8'h00, scan_window[7:0]};
                    r.word_a = slp_a_word;
                    r.word_b = wide << SLP_SHIFT;
                end
            end
            else
                r.status = ST_TRUNC;
            s5_results_due.push_back(r);
            clear_scan();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Input side: hold a request until taken, then offer the next queued
    // byte unless the idle roll or a drain pause says otherwise.
    always @(posedge clk) begin
        byte_req_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else begin
            if (s_tvalid && s_tready)
                parse_body_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (byte_reqs.size() != 0 &&
                    !(byte_reqs[0].drain_first && s5_results_due.size() != 0) &&
                    $urandom_range(99) >= byte_reqs[0].idle_pct) begin
                    nxt = byte_reqs.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= nxt.data;
                    s_tlast    <= nxt.is_last;
                    recv_stall <= nxt.stall_pct;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: check each taken result against the oldest one due,
    // then roll the stall for the next cycle.
    always @(posedge clk) begin
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else begin
            if (m_tvalid && m_tready) begin
                if (s5_results_due.size() == 0)
                    flag_mismatch("result with none due", 16'(m_tdata[2:0]), '0);
                else begin
                    want = s5_results_due.pop_front();
                    if (m_tdata[2:0] != want.status)
                        flag_mismatch("status", 16'(m_tdata[2:0]), 16'(want.status));
                    if (m_tdata[18:3] != want.word_a)
                        flag_mismatch("sleep_word_a", m_tdata[18:3], want.word_a);
                    if (m_tdata[34:19] != want.word_b)
                        flag_mismatch("sleep_word_b", m_tdata[34:19], want.word_b);
                    if (m_tdata[OUT_W-1:35] != '0)
                        flag_mismatch("pad bits", 16'(m_tdata[OUT_W-1:35]), '0);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("aml_s5_sleep_type_extractor_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic queue_body(input body_t body);
        byte_req_t r;
        foreach (body[i]) begin
            r.data        = body[i];
            r.is_last     = (i == body.size() - 1);
            r.idle_pct    = gen_idle;
            r.stall_pct   = gen_stall;
            r.drain_first = gen_drain && (i == 0);
            byte_reqs.push_back(r);
        end
        gen_drain    = 1'b0;
        bytes_queued += body.size();
    endtask

    task automatic push_s5_name(ref body_t body);
        body.push_back(NAME_S5[31:24]);
        body.push_back(NAME_S5[23:16]);
        body.push_back(NAME_S5[15:8]);
        body.push_back(NAME_S5[7:0]);
    endtask

    // Mostly well-formed _S5_ packages with random content and framing
    // faults; the rest is plain noise, with or without a bare name.
    task automatic random_body(output body_t body);
        int         n;
        int         form;
        logic [7:0] lead;
        body = {};
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
            if ($urandom_range(1))
                push_s5_name(body);
            repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
            if (body.size() == 0)
                body.push_back(8'($urandom));
        end
        else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 3);
            repeat (n) body.push_back(8'($urandom));
            form = $urandom_range(9);
            if (form < 5)
                body.push_back(OP_NAME);
            else if (form < 8) begin
                body.push_back(OP_NAME);
                body.push_back(BACKSLASH);
            end
            else if (form == 8)
                body.push_back(8'($urandom));
            push_s5_name(body);
            body.push_back(($urandom_range(9) == 0) ? 8'($urandom) : OP_PACKAGE);
            lead = 8'($urandom);
            body.push_back(lead);
            repeat (lead[7:6]) body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            if ($urandom_range(1))
                body.push_back(OP_BYTE_PREFIX);
            body.push_back(8'($urandom));
            if ($urandom_range(1))
                body.push_back(OP_BYTE_PREFIX);
            body.push_back(8'($urandom));
            repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
            // a later, well-formed name must not override the first one
            if ($urandom_range(6) == 0) begin
                body.push_back(OP_NAME);
                push_s5_name(body);
                body.push_back(OP_PACKAGE);
            end
            // cut the body short now and then
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, body.size());
                while (body.size() > n)
                    void'(body.pop_back());
            end
        end
    endtask

    initial begin
        body_t body;
        int    seg;
        int    cur_seg;

        // Directed bodies, no idling: one-byte body, name at offset 0,
        // root-prefixed name with four length bytes and both prefixes,
        // missing package op, missing name op, body ending at the package length byte.
        body = '{8'hFF};
        queue_body(body);
        body = '{8'h5F, 8'h53, 8'h35, 8'h5F};
        queue_body(body);
        body = '{8'h00, OP_NAME, BACKSLASH, 8'h5F, 8'h53, 8'h35, 8'h5F, OP_PACKAGE,
                 8'hC0, 8'h01, 8'h02, 8'h03, 8'h04, OP_BYTE_PREFIX, 8'hFF,
                 OP_BYTE_PREFIX, 8'h80};
        queue_body(body);
        body = '{OP_NAME, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h11};
        queue_body(body);
        body = '{8'h07, 8'h5F, 8'h53, 8'h35, 8'h5F, OP_PACKAGE};
        queue_body(body);
        body = '{OP_NAME, 8'h5F, 8'h53, 8'h35, 8'h5F, OP_PACKAGE, 8'h00};
        queue_body(body);

        // Random bodies in rotating traffic phases; each phase change first
        // waits for every outstanding result.
        cur_seg = 0;
        while (bytes_queued < BYTE_TARGET) begin
            seg = (bytes_queued / PHASE_SPAN) % 4;
            if (seg != cur_seg) begin
                cur_seg   = seg;
                gen_drain = 1'b1;
                gen_idle  = (seg == 1) ? 52 : (seg == 3) ? 18 : 0;
                gen_stall = (seg == 2) ? 52 : (seg == 3) ? 18 : 0;
            end
            random_body(body);
            queue_body(body);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_reqs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (s5_results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("aml_s5_sleep_type_extractor_unit_tb: done, clean");
        else
            $display("aml_s5_sleep_type_extractor_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/s5ste_pkg.sv
sv/aml_s5_sleep_type_extractor_unit.sv
tb/aml_s5_sleep_type_extractor_unit_tb.sv
